// ===== src/dag_transitive_reduction_macros.svh =====
// Assertion macros for the transitive reduction block checker.
// Expects clk and rst to be in scope where the macros are used.
`ifndef DAG_TRANSITIVE_REDUCTION_MACROS_SVH
`define DAG_TRANSITIVE_REDUCTION_MACROS_SVH

// same-cycle implication, off during reset
`define DTR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define DTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define DTR_ASSERT_NEXT_RAW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dtr_pkg.sv =====
// Shared types and constants for the transitive reduction block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtr_pkg;

  localparam int MAX_NODES = 64;
  localparam int LIM       = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REDUCE = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] from_node;
    logic [IDX_W-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [63:0]      kept_successors;
    logic [63:0]      removed_successors;
    logic             unordered;
    logic             last_row;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/dtr_scan.sv =====
// Lowest-set-bit finder shared by the sequencer of the reduction block.
// Depends on dtr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtr_scan (
  input  wire logic [dtr_pkg::LIM-1:0]   mask,
  output logic      [dtr_pkg::IDX_W-1:0] idx,
  output logic                           any
);
  import dtr_pkg::*;

  always_comb begin
    idx = '0;
    for (int k = LIM - 1; k >= 0; k--) begin
      if (mask[k]) begin
        idx = IDX_W'(k);
      end
    end
  end

  assign any = |mask;

endmodule

`default_nettype wire

// ===== src/dag_transitive_reduction.sv =====
// Top level of the DAG transitive reduction block: edge store, sequencer, config port.
// Depends on dtr_pkg and dtr_scan.
//
// Usage:
//   Input beats (in_valid/in_ready) carry an action: add edge, reduce, clear.
//   An add reads, merges and writes back one adjacency row; a clear acts in
//   its accepting cycle. in_ready is high only while the sequencer is idle.
//   After its accepting cycle a reduce walks the rows: it counts in-degrees
//   row by row, builds a Kahn ordering of the nodes, then accumulates
//   reachability over the ordered nodes in reverse order, then for each node
//   merges the reachability of its ordered successors before its row is
//   shown. The scan unit and the single read port of each row memory set
//   this sequence.
//   Each result row sits in the output register until out_ready takes it;
//   a stalled receiver holds the sequencer. n rows are sent per reduce, the
//   last one flagged with last_row.
//   Reset (rst, synchronous) empties the edge store through row valid bits,
//   sets node_count to 64 and drops any pending result.
//   node_count lives at APB address 0; writes take effect on the next beat.
`timescale 1ns / 1ps
`default_nettype none

module dag_transitive_reduction (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dtr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dtr_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import dtr_pkg::*;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_IND_RD, S_IND_USE, S_KAHN_INIT, S_KAHN_PICK,
    S_KAHN_USE, S_RCH_TOPO, S_RCH_ADJ, S_RCH_ROW, S_RCH_SCAN, S_RCH_ACC,
    S_EMT_ADJ, S_EMT_ROW, S_EMT_SCAN, S_EMT_ACC, S_EMT_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] n_eff;
  logic [LIM-1:0]   use_mask;

  logic [63:0]      adj_mem [LIM];
  logic [LIM-1:0]   valid_row;
  logic [63:0]      adj_q;
  logic             adj_vq;
  logic [IDX_W-1:0] adj_rd_addr;
  logic [LIM-1:0]   adj_row;

  logic [63:0]      reach_mem [LIM];
  logic [63:0]      reach_q;
  logic [IDX_W-1:0] topo_mem [LIM];
  logic [IDX_W-1:0] topo_q;

  logic [CNT_W-1:0] indeg [LIM];
  logic [LIM-1:0]   ready_mask;
  logic [LIM-1:0]   ordered;
  logic [LIM-1:0]   pend;
  logic [63:0]      row_r;
  logic [63:0]      acc;
  logic [CNT_W-1:0] row_idx;
  logic [CNT_W-1:0] order_len;
  logic [IDX_W-1:0] cur_node;
  logic [IDX_W-1:0] scan_j;
  logic [IDX_W-1:0] add_from;
  logic [IDX_W-1:0] add_to;

  logic [LIM-1:0]   scan_mask;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_any;
  logic             cfg_wr;
  logic [63:0]      via;

  assign pready   = 1'b1;
  assign in_ready = !rst && (state == S_IDLE);
  assign cfg_wr   = psel & penable & pwrite & pready & (paddr[2] == REG_NODE_COUNT);
  assign prdata   = (paddr[2] == REG_NODE_COUNT) ? {25'd0, node_count} : 32'd0;

  always_comb begin
    if (node_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count > CNT_W'(LIM)) begin
      n_eff = CNT_W'(LIM);
    end else begin
      n_eff = node_count;
    end
    for (int j = 0; j < LIM; j++) begin
      use_mask[j] = (CNT_W'(j) < n_eff);
    end
  end

  always_comb begin
    case (state)
      S_ADD_RD:    adj_rd_addr = add_from;
      S_KAHN_PICK: adj_rd_addr = scan_idx;
      S_RCH_ADJ:   adj_rd_addr = topo_q;
      default:     adj_rd_addr = row_idx[IDX_W-1:0];
    endcase
  end

  assign adj_row   = (adj_vq ? adj_q[LIM-1:0] : '0) & use_mask;
  assign scan_mask = (state == S_KAHN_PICK) ? ready_mask : pend;
  assign via       = acc & {{(64-LIM){1'b0}}, row_r[LIM-1:0]};

  dtr_scan u_scan (
    .mask (scan_mask),
    .idx  (scan_idx),
    .any  (scan_any)
  );

  always_ff @(posedge clk) begin
    adj_q   <= adj_mem[adj_rd_addr];
    adj_vq  <= valid_row[adj_rd_addr];
    reach_q <= reach_mem[scan_idx];
    topo_q  <= topo_mem[IDX_W'(row_idx - CNT_W'(1))];
    if (state == S_ADD_WR) begin
      adj_mem[add_from] <= (adj_vq ? adj_q : 64'd0) | (64'd1 << add_to);
    end
    if (state == S_RCH_SCAN && !scan_any) begin
      reach_mem[cur_node] <= acc;
    end
    if (state == S_KAHN_PICK && scan_any) begin
      topo_mem[order_len[IDX_W-1:0]] <= scan_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= CNT_W'(64);
      valid_row  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        node_count <= pwdata[CNT_W-1:0];
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (in_data.action)
              ACT_ADD: begin
                if ({1'b0, in_data.from_node} < CNT_W'(LIM) &&
                    {1'b0, in_data.to_node} < CNT_W'(LIM)) begin
                  add_from <= in_data.from_node;
                  add_to   <= in_data.to_node;
                  state    <= S_ADD_RD;
                end
              end
              ACT_REDUCE: begin
                row_idx    <= '0;
                order_len  <= '0;
                ready_mask <= '0;
                ordered    <= '0;
                for (int j = 0; j < LIM; j++) begin
                  indeg[j] <= '0;
                end
                state <= S_IND_RD;
              end
              ACT_CLEAR: valid_row <= '0;
              default: ;
            endcase
          end
        end
        S_ADD_RD: state <= S_ADD_WR;
        S_ADD_WR: begin
          valid_row[add_from] <= 1'b1;
          state               <= S_IDLE;
        end
        S_IND_RD: state <= S_IND_USE;
        S_IND_USE: begin
          for (int j = 0; j < LIM; j++) begin
            indeg[j] <= indeg[j] + CNT_W'(adj_row[j]);
          end
          if (row_idx + CNT_W'(1) == n_eff) begin
            state <= S_KAHN_INIT;
          end else begin
            row_idx <= row_idx + CNT_W'(1);
            state   <= S_IND_RD;
          end
        end
        S_KAHN_INIT: begin
          for (int j = 0; j < LIM; j++) begin
            ready_mask[j] <= use_mask[j] && (indeg[j] == '0);
          end
          state <= S_KAHN_PICK;
        end
        S_KAHN_PICK: begin
          if (scan_any) begin
            ready_mask[scan_idx] <= 1'b0;
            ordered[scan_idx]    <= 1'b1;
            order_len            <= order_len + CNT_W'(1);
            state                <= S_KAHN_USE;
          end else begin
            row_idx <= order_len;
            state   <= S_RCH_TOPO;
          end
        end
        S_KAHN_USE: begin
          for (int j = 0; j < LIM; j++) begin
            if (adj_row[j]) begin
              indeg[j] <= indeg[j] - CNT_W'(1);
              if (indeg[j] == CNT_W'(1)) begin
                ready_mask[j] <= 1'b1;
              end
            end
          end
          state <= S_KAHN_PICK;
        end
        S_RCH_TOPO: begin
          if (row_idx == '0) begin
            state <= S_EMT_ADJ;
          end else begin
            state <= S_RCH_ADJ;
          end
        end
        S_RCH_ADJ: begin
          cur_node <= topo_q;
          state    <= S_RCH_ROW;
        end
        S_RCH_ROW: begin
          pend  <= adj_row & ordered;
          acc   <= 64'd1 << cur_node;
          state <= S_RCH_SCAN;
        end
        S_RCH_SCAN: begin
          if (scan_any) begin
            pend[scan_idx] <= 1'b0;
            state          <= S_RCH_ACC;
          end else begin
            row_idx <= row_idx - CNT_W'(1);
            state   <= S_RCH_TOPO;
          end
        end
        S_RCH_ACC: begin
          acc   <= acc | reach_q;
          state <= S_RCH_SCAN;
        end
        S_EMT_ADJ: state <= S_EMT_ROW;
        S_EMT_ROW: begin
          row_r <= {{(64-LIM){1'b0}}, adj_row};
          pend  <= adj_row & ordered;
          acc   <= '0;
          state <= S_EMT_SCAN;
        end
        S_EMT_SCAN: begin
          if (scan_any) begin
            pend[scan_idx] <= 1'b0;
            scan_j         <= scan_idx;
            state          <= S_EMT_ACC;
          end else begin
            out_data.node               <= row_idx[IDX_W-1:0];
            out_data.kept_successors    <= row_r & ~via;
            out_data.removed_successors <= via;
            out_data.unordered          <= ~ordered[row_idx[IDX_W-1:0]];
            out_data.last_row           <= (row_idx + CNT_W'(1) == n_eff);
            out_valid                   <= 1'b1;
            state                       <= S_EMT_OUT;
          end
        end
        S_EMT_ACC: begin
          acc   <= acc | (reach_q & ~(64'd1 << scan_j));
          state <= S_EMT_SCAN;
        end
        S_EMT_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (row_idx + CNT_W'(1) == n_eff) begin
              state <= S_IDLE;
            end else begin
              row_idx <= row_idx + CNT_W'(1);
              state   <= S_EMT_ADJ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/dtr_checker.sv =====
// Port-level assertions for the transitive reduction block, bound to the top level.
// Depends on dtr_pkg and dag_transitive_reduction_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dag_transitive_reduction_macros.svh"

module dtr_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire dtr_pkg::out_item_t out_data
);
  import dtr_pkg::*;

  logic both_set;

  assign both_set = |(out_data.kept_successors & out_data.removed_successors);

  `DTR_ASSERT_NEXT_RAW(a_reset_idle, rst, !out_valid, "result pending after reset")
  `DTR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "beat changed")
  `DTR_ASSERT_IMP(a_busy, out_valid, !in_ready, "input taken while a row is pending")
  `DTR_ASSERT_NEXT(a_last, out_valid && out_ready && out_data.last_row, !out_valid, "row after last")
  `DTR_ASSERT_IMP(a_disjoint, out_valid, !both_set, "edge both kept and removed")

endmodule

bind dag_transitive_reduction dtr_checker u_dtr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
